// ===== rtl/pixel_to_tiled_rgba8_swizzle_top_macros.svh =====
// ----------------------------------------------------------------------------
// pixel to tiled rgba8 swizzle assertion macros
// concurrent checks, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_TILED_RGBA8_SWIZZLE_TOP_MACROS_SVH
`define PIXEL_TO_TILED_RGBA8_SWIZZLE_TOP_MACROS_SVH

// same-cycle implication
`define PTRS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ptrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_pkg
// shared constants, register indexes and color expansion helpers
// ----------------------------------------------------------------------------
package ptrs_pkg;

	localparam int MAX_DIMENSION = 1024;

	localparam int DIM_W     = 11;
	localparam int COORD_W   = 10;
	localparam int RAW_W     = 32;
	localparam int ADDR_W    = 22;
	localparam int WORD_W    = 16;
	localparam int TROW_W    = 9;
	localparam int TILE_W    = 17;
	localparam int S_DATA_W  = 56;
	localparam int M_DATA_W  = 80;
	localparam int CFG_IDX_W = 2;

	localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIMENSION);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIX_TYPE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA = 2'd3;

	// pixel types
	localparam logic [1:0] PIX_BYTES = 2'd0;
	localparam logic [1:0] PIX_5551  = 2'd1;
	localparam logic [1:0] PIX_565   = 2'd2;
	localparam logic [1:0] PIX_4444  = 2'd3;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		return (d > MAX_DIM_V) ? MAX_DIM_V : d;
	endfunction

	// floor(v*255/31) = 8v + floor(7v/31)
	function automatic logic [7:0] scale5(input logic [4:0] v);
		logic [7:0] v7;
		logic [2:0] q;
		v7 = 8'(v) * 8'd7;
		q  = '0;
		for (int k = 1; k <= 7; k++) begin
			if (v7 >= 8'(31 * k))
				q = q + 3'd1;
		end
		return {v, 3'b000} + 8'(q);
	endfunction

	// floor(v*255/63) = 4v + floor(v/21)
	function automatic logic [7:0] scale6(input logic [5:0] v);
		logic [1:0] q;
		q = '0;
		for (int k = 1; k <= 3; k++) begin
			if (v >= 6'(21 * k))
				q = q + 2'd1;
		end
		return {v, 2'b00} + 8'(q);
	endfunction

	function automatic logic [7:0] scale4(input logic [3:0] v);
		return {v, v};
	endfunction

endpackage

// ===== rtl/pixel_to_tiled_rgba8_swizzle_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_tiled_rgba8_swizzle_top
// expands one source pixel to rgba8 and maps it to its two 16-bit writes
// in a 4x4 tiled texture layout
// ----------------------------------------------------------------------------
//  channel  | dir | signals                         | payload
//  s        | in  | s_tvalid s_tready s_tdata        | pixel_x pixel_y raw_pixel
//  m        | out | m_tvalid m_tready m_tdata m_tuser| addresses, words, in_range
//  cfg      | in  | cfg_we cfg_index cfg_data        | texture registers
//
//  one pixel per cycle while m_tready does not hold the result; an s transfer loads
//  the input register, and the pixel then passes through the result register
//  after the expand and tile multiply before m_tvalid rises
//  arst_n clears valid flags and loads the register reset values
//  m_tready low holds the result; s_tready stays high while the input
//  register can move forward or is empty
// ----------------------------------------------------------------------------
`include "pixel_to_tiled_rgba8_swizzle_top_macros.svh"

module pixel_to_tiled_rgba8_swizzle_top
	import ptrs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // pixel_x, pixel_y, raw_pixel, zero pad
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // ar_address, ar_word, gb_address, gb_word, pad
	output logic                 m_tuser,   // in_range
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [1:0]       pix_type_q;
	logic             has_alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= DIM_W'(1);
			height_q    <= DIM_W'(1);
			pix_type_q  <= PIX_BYTES;
			has_alpha_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:     width_q     <= cfg_data;
				REG_HEIGHT:    height_q    <= cfg_data;
				REG_PIX_TYPE:  pix_type_q  <= cfg_data[1:0];
				REG_HAS_ALPHA: has_alpha_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic valid_s1, valid_s2, advance;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	// input register
	logic [COORD_W-1:0] x_s1, y_s1;
	logic [RAW_W-1:0]   raw_s1;

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			x_s1   <= s_tdata[COORD_W-1:0];
			y_s1   <= s_tdata[2*COORD_W-1:COORD_W];
			raw_s1 <= s_tdata[2*COORD_W+RAW_W-1:2*COORD_W];
		end
	end

	// expand and address
	logic [DIM_W-1:0]   w_c, h_c;
	logic [DIM_W:0]     w_up;
	logic [TROW_W-1:0]  tiles_row;
	logic [TILE_W-1:0]  tile_idx;
	logic               in_rng;
	logic [15:0]        v;
	logic [7:0]         r, g, b, a;
	logic [ADDR_W-1:0]  ar_addr, gb_addr;

	always_comb begin
		w_c       = clamp_dim(width_q);
		h_c       = clamp_dim(height_q);
		in_rng    = ({1'b0, x_s1} < w_c) && ({1'b0, y_s1} < h_c);
		w_up      = {1'b0, w_c} + (DIM_W+1)'(3);
		tiles_row = w_up[TROW_W+1:2];
		tile_idx  = TILE_W'(y_s1[COORD_W-1:2]) * TILE_W'(tiles_row)
			+ TILE_W'(x_s1[COORD_W-1:2]);
		// tile base is tile*64, offset fills bits 4:1, bit 5 picks the gb half
		ar_addr   = ADDR_W'({tile_idx, 1'b0, y_s1[1:0], x_s1[1:0], 1'b0});
		gb_addr   = ADDR_W'({tile_idx, 1'b1, y_s1[1:0], x_s1[1:0], 1'b0});

		v = raw_s1[15:0];
		case (pix_type_q)
			PIX_BYTES: begin
				r = raw_s1[7:0];
				g = raw_s1[15:8];
				b = raw_s1[23:16];
				a = has_alpha_q ? raw_s1[31:24] : 8'hff;
			end
			PIX_5551: begin
				r = scale5(v[15:11]);
				g = scale5(v[10:6]);
				b = scale5(v[5:1]);
				a = v[0] ? 8'hff : 8'h00;
			end
			PIX_565: begin
				r = scale5(v[15:11]);
				g = scale6(v[10:5]);
				b = scale5(v[4:0]);
				a = 8'hff;
			end
			default: begin
				r = scale4(v[15:12]);
				g = scale4(v[11:8]);
				b = scale4(v[7:4]);
				a = scale4(v[3:0]);
			end
		endcase
	end

	// result register
	logic [ADDR_W-1:0] ar_addr_s2, gb_addr_s2;
	logic [WORD_W-1:0] ar_word_s2, gb_word_s2;
	logic              in_rng_s2;

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			in_rng_s2  <= in_rng;
			ar_addr_s2 <= in_rng ? ar_addr : '0;
			gb_addr_s2 <= in_rng ? gb_addr : '0;
			ar_word_s2 <= in_rng ? {a, r} : '0;
			gb_word_s2 <= in_rng ? {g, b} : '0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = in_rng_s2;
	assign m_tdata  = {4'b0000, gb_word_s2, gb_addr_s2, ar_word_s2, ar_addr_s2};

	`PTRS_ASSERT_SAME(a_out_zero, m_tvalid && !m_tuser, m_tdata == '0, "out of range result not zero")
	`PTRS_ASSERT_SAME(a_gb_offset, m_tvalid && m_tuser,
		m_tdata[59:38] == m_tdata[21:0] + 22'd32, "gb address is not ar address plus 32")
	`PTRS_ASSERT_SAME(a_even_addr, m_tvalid, !m_tdata[0] && !m_tdata[38], "odd word address")
	`PTRS_ASSERT_NEXT(a_take_s1, s_tvalid && s_tready, valid_s1, "accepted transfer lost at input register")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for pixel_to_tiled_rgba8_swizzle_top
// drives pixels with coordinates over the input stream and checks each
// tiled write pair against a local model of the color expansion, the
// 4x4 tile address math and the bounds check, across several texture setups
// ----------------------------------------------------------------------------
module testbench;
	import ptrs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int PHASES         = 10;
	localparam int PHASE_PIXELS   = 200;

	typedef struct packed {
		logic [ADDR_W-1:0] ar_addr;
		logic [WORD_W-1:0] ar_word;
		logic [ADDR_W-1:0] gb_addr;
		logic [WORD_W-1:0] gb_word;
		logic              in_range;
	} tile_write_t;

	typedef enum {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_RARE} ready_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;    // pixel_x, pixel_y, raw_pixel, zero pad
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;         // ar_address, ar_word, gb_address, gb_word, pad
	logic                 m_tuser;         // in_range
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
	logic [DIM_W-1:0]     cfg_data = '0;

	// local copy of the texture registers, at their reset values
	logic [DIM_W-1:0] cur_width  = 11'd1;
	logic [DIM_W-1:0] cur_height = 11'd1;
	logic [1:0]       cur_type   = PIX_BYTES;
	logic             cur_alpha  = 1'b1;

	tile_write_t pending_writes[$];
	tile_write_t next_write;
	int          mismatch_count = 0;
	int          burst_left = 0;
	int          idle_cycles = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int          ready_mode_left = 0;

	pixel_to_tiled_rgba8_swizzle_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] dim);
		return (dim > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : dim;
	endfunction

	function automatic logic [7:0] widen5(input logic [4:0] v);
		return 8'((int'(v) * 255) / 31);
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		return 8'((int'(v) * 255) / 63);
	endfunction

	function automatic logic [7:0] widen4(input logic [3:0] v);
		return 8'(int'(v) * 17);
	endfunction

	function automatic tile_write_t predict_tile_write(input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py, input logic [RAW_W-1:0] raw);
		tile_write_t      tw;
		logic [DIM_W-1:0] w_eff;
		logic [DIM_W-1:0] h_eff;
		logic [15:0]      v;
		logic [7:0]       r, g, b, a;
		int               tiles_per_row;
		logic [ADDR_W-1:0] ar_addr;
		tw = '0;
		w_eff = effective_dim(cur_width);
		h_eff = effective_dim(cur_height);
		if (DIM_W'(px) >= w_eff || DIM_W'(py) >= h_eff)
			return tw;
		v = raw[15:0];
		a = 8'hFF;
		case (cur_type)
			PIX_BYTES: begin
				r = raw[7:0];
				g = raw[15:8];
				b = raw[23:16];
				if (cur_alpha)
					a = raw[31:24];
			end
			PIX_5551: begin
				r = widen5(v[15:11]);
				g = widen5(v[10:6]);
				b = widen5(v[5:1]);
				a = v[0] ? 8'hFF : 8'h00;
			end
			PIX_565: begin
				r = widen5(v[15:11]);
				g = widen6(v[10:5]);
				b = widen5(v[4:0]);
			end
			default: begin
				r = widen4(v[15:12]);
				g = widen4(v[11:8]);
				b = widen4(v[7:4]);
				a = widen4(v[3:0]);
			end
		endcase
		tiles_per_row = (int'(w_eff) + 3) / 4;
		ar_addr = ADDR_W'(((int'(py) / 4) * tiles_per_row + int'(px) / 4) * 64
			+ ((int'(py) % 4) * 4 + int'(px) % 4) * 2);
		tw.ar_addr  = ar_addr;
		tw.ar_word  = {a, r};
		tw.gb_addr  = ar_addr + ADDR_W'(32);
		tw.gb_word  = {g, b};
		tw.in_range = 1'b1;
		return tw;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// sender works in bursts; valid stays high from one transfer to the next within a burst
	task automatic push_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
			input logic [RAW_W-1:0] raw);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tdata  = {4'b0000, raw, py, px};
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_writes.push_back(predict_tile_write(px, py, raw));
		burst_left--;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_writes.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_WIDTH:    cur_width  = value;
			REG_HEIGHT:   cur_height = value;
			REG_PIX_TYPE: cur_type   = value[1:0];
			default:      cur_alpha  = value[0];
		endcase
	endtask

	task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic [1:0] ptype, input logic alpha);
		wait_drained();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_PIX_TYPE, DIM_W'(ptype));
		write_reg(REG_HAS_ALPHA, DIM_W'(alpha));
	endtask

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0:       return 11'd0;
			1:       return 11'd1;
			2:       return 11'd1024;
			3:       return 11'd2047;
			4:       return DIM_W'($urandom_range(1025, 2047));
			5, 6:    return DIM_W'($urandom_range(1, 16));
			default: return DIM_W'($urandom_range(1, 1024));
		endcase
	endfunction

	// mostly inside the texture, the rest anywhere in the coordinate range
	function automatic logic [COORD_W-1:0] pick_coord(input logic [DIM_W-1:0] dim);
		logic [DIM_W-1:0] eff;
		eff = effective_dim(dim);
		if (eff != 0 && $urandom_range(0, 9) < 8)
			return COORD_W'($urandom_range(0, int'(eff) - 1));
		return COORD_W'($urandom_range(0, 1023));
	endfunction

	// reset values: 1x1 texture, byte type with alpha
	task automatic test_reset_values();
		push_pixel(10'd0, 10'd0, 32'hA1B2C3D4);
		push_pixel(10'd1, 10'd0, 32'h11223344);
		push_pixel(10'd0, 10'd1, 32'h55667788);
		push_pixel(10'd1023, 10'd1023, 32'hFFFFFFFF);
	endtask

	task automatic test_pixel_formats();
		configure(11'd8, 11'd8, PIX_BYTES, 1'b1);
		push_pixel(10'd7, 10'd7, 32'hFFFFFFFF);
		push_pixel(10'd0, 10'd0, 32'h00000000);
		configure(11'd8, 11'd8, PIX_BYTES, 1'b0);
		push_pixel(10'd3, 10'd5, 32'h12345678);
		configure(11'd8, 11'd8, PIX_5551, 1'b1);
		push_pixel(10'd4, 10'd1, 32'h0000FFFF);
		push_pixel(10'd2, 10'd2, 32'hFFFE0001);   // upper bits must be ignored
		configure(11'd8, 11'd8, PIX_565, 1'b0);
		push_pixel(10'd5, 10'd3, 32'hFFFFFFFF);
		push_pixel(10'd1, 10'd6, 32'hA5A5F81F);
		configure(11'd8, 11'd8, PIX_4444, 1'b1);
		push_pixel(10'd6, 10'd0, 32'h0000FFFF);
		push_pixel(10'd0, 10'd7, 32'h12345A3C);
	endtask

	task automatic test_texture_bounds();
		// zero width: nothing is in range
		configure(11'd0, 11'd8, PIX_BYTES, 1'b1);
		push_pixel(10'd0, 10'd0, 32'hDEADBEEF);
		// oversized registers saturate to the maximum dimension
		configure(11'd2047, 11'd2047, PIX_BYTES, 1'b1);
		push_pixel(10'd1023, 10'd1023, 32'hCAFEF00D);
		configure(11'd1025, 11'd1, PIX_565, 1'b1);
		push_pixel(10'd1023, 10'd0, 32'h0000ABCD);
		push_pixel(10'd1, 10'd1, 32'h0000ABCD);
		// width not a multiple of the tile size
		configure(11'd5, 11'd1024, PIX_4444, 1'b0);
		push_pixel(10'd4, 10'd1023, 32'h00009876);
		push_pixel(10'd5, 10'd0, 32'h00009876);
	endtask

	task automatic test_random_traffic();
		logic [DIM_W-1:0] w, h;
		for (int phase = 0; phase < PHASES; phase++) begin
			w = (phase == 0) ? 11'd1024 : pick_dim();
			h = (phase == 0) ? 11'd1024 : pick_dim();
			configure(w, h, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				// hold off the sender once per phase until the output side is empty
				if (i == PHASE_PIXELS / 2)
					wait_drained();
				push_pixel(pick_coord(w), pick_coord(h), $urandom());
			end
		end
	endtask

	// receiver stall pattern, switching between modes
	always @(negedge clk) begin
		if (ready_mode_left == 0) begin
			ready_mode      = ready_mode_t'($urandom_range(0, 3));
			ready_mode_left = $urandom_range(16, 96);
		end
		ready_mode_left--;
		case (ready_mode)
			READY_ALWAYS: m_tready = 1'b1;
			READY_HALF:   m_tready = 1'($urandom_range(0, 1));
			READY_MOSTLY: m_tready = ($urandom_range(0, 7) != 0);
			default:      m_tready = ($urandom_range(0, 5) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_writes.size() == 0) begin
				report_mismatch("transfer with no pixel pending", 32'(m_tdata[ADDR_W-1:0]), '0);
			end else begin
				next_write = pending_writes.pop_front();
				if (m_tdata[21:0] !== next_write.ar_addr)
					report_mismatch("ar_address", 32'(m_tdata[21:0]), 32'(next_write.ar_addr));
				if (m_tdata[37:22] !== next_write.ar_word)
					report_mismatch("ar_word", 32'(m_tdata[37:22]), 32'(next_write.ar_word));
				if (m_tdata[59:38] !== next_write.gb_addr)
					report_mismatch("gb_address", 32'(m_tdata[59:38]), 32'(next_write.gb_addr));
				if (m_tdata[75:60] !== next_write.gb_word)
					report_mismatch("gb_word", 32'(m_tdata[75:60]), 32'(next_write.gb_word));
				if (m_tuser !== next_write.in_range)
					report_mismatch("in_range", 32'(m_tuser), 32'(next_write.in_range));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_reset_values();
		test_pixel_formats();
		test_texture_bounds();
		test_random_traffic();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_writes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
